// File: src/pfc_pkg.sv
package pfc_pkg;

    // letter and cell codes
    typedef logic [4:0] t_letter;
    typedef logic [4:0] t_cell;
    typedef logic [2:0] t_coord;

    localparam t_letter LTR_I    = 5'd8;
    localparam t_letter LTR_J    = 5'd9;
    localparam t_letter LTR_LAST = 5'd25;

    localparam int     NUM_CELLS = 25;
    localparam t_cell  CELL_LAST = 5'(NUM_CELLS - 1);
    localparam t_coord SIDE_LAST = 3'd4;

    // input function codes
    localparam logic [2:0] FN_KEY    = 3'd0;
    localparam logic [2:0] FN_FINISH = 3'd1;
    localparam logic [2:0] FN_PLAIN  = 3'd2;
    localparam logic [2:0] FN_END    = 3'd3;
    localparam logic [2:0] FN_CIPHER = 3'd4;

    // register indexes on the config port
    localparam logic REG_MERGE  = 1'b0;
    localparam logic REG_FILLER = 1'b1;

    localparam logic [3:0] MERGE_RESET  = 4'd8;
    localparam logic [4:0] FILLER_RESET = 5'd23;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_KEY,
        OP_FILL,
        OP_PAIR
    } t_op;

    typedef struct packed {
        t_op     op;
        t_letter a;
        t_letter b;
        logic    dec;
    } t_cmd;

    typedef struct packed {
        logic [3:0] merge;
        logic [4:0] filler;
    } t_cfg;

    // letter that stands for both i and j
    function automatic t_letter merged(input logic [3:0] m);
        return (m == 4'(LTR_J)) ? LTR_J : LTR_I;
    endfunction

    function automatic t_letter map_letter(input t_letter x, input logic [3:0] m);
        return (x == LTR_I || x == LTR_J) ? merged(m) : x;
    endfunction

    // i and j share one cell slot: 26 letters fold onto 25 slots
    function automatic t_cell fold(input t_letter x);
        return (x > LTR_I) ? t_cell'(x - 5'd1) : t_cell'(x);
    endfunction

    // letter of a folded slot, in alphabetical order
    function automatic t_letter slot_letter(input t_cell c, input logic [3:0] m);
        t_letter res;
        if (c < LTR_I) begin
            res = c;
        end else if (c == LTR_I) begin
            res = merged(m);
        end else begin
            res = c + 5'd1;
        end
        return res;
    endfunction

    function automatic t_coord cell_row(input t_cell p);
        t_coord r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic t_coord cell_col(input t_cell p, input t_coord r);
        t_cell base;
        base = {r, 2'b00} + {2'b00, r};
        return t_coord'(p - base);
    endfunction

    // one step around the side, forward or back
    function automatic t_coord wrap_step(input t_coord v, input logic dec);
        t_coord res;
        if (dec) begin
            res = (v == 3'd0) ? SIDE_LAST : v - 3'd1;
        end else begin
            res = (v == SIDE_LAST) ? 3'd0 : v + 3'd1;
        end
        return res;
    endfunction

    function automatic t_cell cell_index(input t_coord r, input t_coord c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

// File: src/pfc_in_if.sv
interface pfc_in_if import pfc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] func;
    t_letter    letter;

    modport source (output valid, output func, output letter, input ready);
    modport sink (input valid, input func, input letter, output ready);
endinterface

// File: src/pfc_out_if.sv
interface pfc_out_if import pfc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_letter first_letter;
    t_letter second_letter;
    logic    is_decrypt;

    modport source (output valid, output first_letter, output second_letter,
                    output is_decrypt, input ready);
    modport sink (input valid, input first_letter, input second_letter,
                  input is_decrypt, output ready);
endinterface

// File: src/pfc_front.sv
module pfc_front import pfc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfc_in_if.sink    i_in,
    input  t_cfg      i_cfg,
    input  logic      i_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic    r_ready_sq, n_ready_sq;
    logic    r_held_v, n_held_v;
    t_letter r_held, n_held;

    logic    w_acc;
    logic    w_valid_l;
    t_letter w_x;
    t_letter w_held_m;
    t_letter w_fill;

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && !i_full;

    // letter folding and filler clamp
    always_comb begin
        w_valid_l = (i_in.letter <= LTR_LAST);
        w_x       = map_letter(i_in.letter, i_cfg.merge);
        w_held_m  = map_letter(r_held, i_cfg.merge);
        w_fill    = map_letter((i_cfg.filler > LTR_LAST) ? LTR_LAST : i_cfg.filler,
                               i_cfg.merge);
    end

    // classify the beat and pair up letters
    always_comb begin
        n_ready_sq = r_ready_sq;
        n_held_v   = r_held_v;
        n_held     = r_held;
        o_push     = 1'b0;
        o_cmd      = '{op: OP_PAIR, a: w_held_m, b: w_x, dec: 1'b0};
        if (w_acc) begin
            unique case (i_in.func) inside
                FN_KEY: begin
                    if (!r_ready_sq && w_valid_l) begin
                        o_push   = 1'b1;
                        o_cmd.op = OP_KEY;
                        o_cmd.a  = w_x;
                    end
                end
                FN_FINISH: begin
                    if (!r_ready_sq) begin
                        o_push     = 1'b1;
                        o_cmd.op   = OP_FILL;
                        n_ready_sq = 1'b1;
                    end
                end
                FN_PLAIN, FN_CIPHER: begin
                    if (r_ready_sq && w_valid_l) begin
                        if (!r_held_v) begin
                            n_held   = i_in.letter;
                            n_held_v = 1'b1;
                        end else if (i_in.func == FN_PLAIN && r_held == i_in.letter) begin
                            // doubled letter: pad, keep the new one held
                            o_push  = 1'b1;
                            o_cmd.b = w_fill;
                        end else begin
                            o_push    = 1'b1;
                            o_cmd.dec = (i_in.func == FN_CIPHER);
                            n_held_v  = 1'b0;
                        end
                    end
                end
                FN_END: begin
                    if (r_ready_sq && r_held_v) begin
                        o_push   = 1'b1;
                        o_cmd.b  = w_fill;
                        n_held_v = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_sq <= 1'b0;
            r_held_v   <= 1'b0;
            r_held     <= '0;
        end else begin
            r_ready_sq <= n_ready_sq;
            r_held_v   <= n_held_v;
            r_held     <= n_held;
        end
    end

endmodule

// File: src/pfc_queue.sv
module pfc_queue import pfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr, r_rd;
    logic [QUEUE_CNT_W-1:0] r_cnt;

    logic w_push, w_pop;

    assign o_full  = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QUEUE_CNT_W'(w_push) - QUEUE_CNT_W'(w_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// File: src/pfc_back.sv
module pfc_back import pfc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [3:0] i_merge,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    pfc_out_if.source  o_out
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                 r_state;
    t_cell                r_walk;
    t_cell                r_fill;
    logic [NUM_CELLS-1:0] r_present;

    // square contents and the cell of each letter slot
    t_letter m_square [NUM_CELLS];
    t_cell   m_pos [NUM_CELLS];

    logic    r_v1, r_dec1;
    t_cell   r_pa, r_pb;
    logic    r_v2, r_dec2;
    t_letter r_first, r_second;

    logic    w_adv;
    logic    w_wr;
    t_cell   w_cell;
    t_letter w_letter;
    t_cell   w_key_cell;
    t_coord  w_ra, w_ca, w_rb, w_cb;
    t_cell   w_qa, w_qb;

    assign w_adv      = !r_v2 || o_out.ready;
    assign o_pop      = i_valid && (r_state == ST_IDLE) && w_adv;
    assign w_key_cell = fold(i_cmd.a);

    // square build: one key letter, or one slot of the finishing walk
    always_comb begin
        w_wr     = 1'b0;
        w_cell   = w_key_cell;
        w_letter = i_cmd.a;
        if (r_state == ST_WALK) begin
            w_cell   = r_walk;
            w_letter = slot_letter(r_walk, i_merge);
            w_wr     = !r_present[r_walk];
        end else if (o_pop && i_cmd.op == OP_KEY) begin
            w_wr = !r_present[w_key_cell] && (r_fill < 5'(NUM_CELLS));
        end
    end

    // build control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_walk    <= '0;
            r_fill    <= '0;
            r_present <= '0;
        end else begin
            if (w_wr) begin
                r_present[w_cell] <= 1'b1;
                r_fill            <= r_fill + 5'd1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop && i_cmd.op == OP_FILL) begin
                        r_state <= ST_WALK;
                        r_walk  <= '0;
                    end
                end
                ST_WALK: begin
                    if (r_walk == CELL_LAST) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_walk <= r_walk + 5'd1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            m_square[r_fill] <= w_letter;
            m_pos[w_cell]    <= r_fill;
        end
    end

    // stage 1: look up the cells of both letters
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pa   <= m_pos[fold(i_cmd.a)];
            r_pb   <= m_pos[fold(i_cmd.b)];
            r_dec1 <= i_cmd.dec;
        end
    end

    // row, column and rectangle rules
    always_comb begin
        w_ra = cell_row(r_pa);
        w_rb = cell_row(r_pb);
        w_ca = cell_col(r_pa, w_ra);
        w_cb = cell_col(r_pb, w_rb);
        if (w_ra == w_rb) begin
            w_qa = cell_index(w_ra, wrap_step(w_ca, r_dec1));
            w_qb = cell_index(w_rb, wrap_step(w_cb, r_dec1));
        end else if (w_ca == w_cb) begin
            w_qa = cell_index(wrap_step(w_ra, r_dec1), w_ca);
            w_qb = cell_index(wrap_step(w_rb, r_dec1), w_cb);
        end else begin
            w_qa = cell_index(w_ra, w_cb);
            w_qb = cell_index(w_rb, w_ca);
        end
    end

    // stage 2: read the result letters into the output register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_first  <= m_square[w_qa];
            r_second <= m_square[w_qb];
            r_dec2   <= r_dec1;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= o_pop && (i_cmd.op == OP_PAIR);
            r_v2 <= r_v1;
        end
    end

    assign o_out.valid         = r_v2;
    assign o_out.first_letter  = r_first;
    assign o_out.second_letter = r_second;
    assign o_out.is_decrypt    = r_dec2;

endmodule

// File: src/playfair_digraph_cipher.sv
// channel   dir  payload                                      beat when
// i_in      in   func[2:0], letter[4:0]                       valid && ready
// o_out     out  first_letter[4:0], second_letter[4:0],       valid && ready
//                is_decrypt
// config    in   apb: psel, penable, pwrite, paddr, pwdata    psel && penable && pwrite
//
// the front takes one beat per cycle while its four-entry command queue has room
// a pair result passes the stage 1 and stage 2 registers after its command leaves the queue
// key finish holds the back while it walks the 25 letter slots
// reset is synchronous, active low; no clearing pass, square cells are written before use
// a stalled output holds the back pipeline, then the queue, then i_in.ready
module playfair_digraph_cipher import pfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfc_in_if.sink      i_in,
    pfc_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg r_cfg;
    logic w_push, w_full, w_q_valid, w_pop;
    t_cmd w_push_cmd, w_q_cmd;

    assign pready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.merge  <= MERGE_RESET;
            r_cfg.filler <= FILLER_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_MERGE:  r_cfg.merge  <= pwdata[3:0];
                REG_FILLER: r_cfg.filler <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[2])
            REG_MERGE:  prdata = {28'd0, r_cfg.merge};
            REG_FILLER: prdata = {27'd0, r_cfg.filler};
            default:    prdata = '0;
        endcase
    end

    pfc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    pfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    pfc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_merge (r_cfg.merge),
        .i_valid (w_q_valid),
        .i_cmd   (w_q_cmd),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
